@@ src/lurl_pkg.sv @@
// Package: shared types and constants for the longest unique run length unit
`timescale 1ns / 1ps
package lurl_pkg;

	localparam int CHAR_BITS   = 8;
	localparam int CHAR_VALUES = 1 << CHAR_BITS;
	localparam int LEN_BITS    = 16;

	typedef struct packed {
		logic [CHAR_BITS-1:0] char_byte;
		logic                 end_of_string;
	} char_t;

	typedef struct packed {
		logic [LEN_BITS-1:0] longest_length;
		logic                length_overflow;
	} result_t;

endpackage

@@ src/longest_unique_run_length_unit.sv @@
// Top level: longest run without a repeated byte, one byte per transaction
// Path: the final byte passes through the stage-1 register, then the output register.
// Throughput: one byte per cycle with same-byte updates bypassed around the
// memory; a final byte waits while a stalled result holds the output register.
// Reset: arst_n clears pipeline valids, seen bits and counters at once;
// the position memory needs no clearing and is ready after reset.
`timescale 1ns / 1ps
module longest_unique_run_length_unit #(
	parameter int POSITION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_stall,
	input  lurl_pkg::char_t   char_data,
	output logic              result_valid,
	input  logic              result_stall,
	output lurl_pkg::result_t result_data
);
	import lurl_pkg::*;

	logic                     rd_en;
	logic [CHAR_BITS-1:0]     rd_addr;
	logic [POSITION_BITS-1:0] rd_data;
	logic                     wr_en;
	logic [CHAR_BITS-1:0]     wr_addr;
	logic [POSITION_BITS-1:0] wr_data;
	logic                     out_free;
	logic                     res_valid;
	result_t                  res_data;
	logic                     out_valid_q;
	result_t                  out_data_q;

	lurl_pos_mem #(
		.POSITION_BITS(POSITION_BITS)
	) u_mem (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	lurl_window #(
		.POSITION_BITS(POSITION_BITS)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (char_valid),
		.in_data  (char_data),
		.in_stall (char_stall),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.out_free (out_free),
		.res_valid(res_valid),
		.res_data (res_data)
	);

	assign out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_data_q <= res_data;
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_data_q;

endmodule

@@ src/lurl_pos_mem.sv @@
// Module: last-position memory, one write port and one registered read port
`timescale 1ns / 1ps
module lurl_pos_mem #(
	parameter int POSITION_BITS = 16
) (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [lurl_pkg::CHAR_BITS-1:0] rd_addr,
	output logic [POSITION_BITS-1:0]       rd_data,
	input  logic                           wr_en,
	input  logic [lurl_pkg::CHAR_BITS-1:0] wr_addr,
	input  logic [POSITION_BITS-1:0]       wr_data
);
	import lurl_pkg::*;

	logic [POSITION_BITS-1:0] mem [CHAR_VALUES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ src/lurl_window.sv @@
// Module: window tracking stage with seen bits, counters and write-back bypass
`timescale 1ns / 1ps
module lurl_window #(
	parameter int POSITION_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  lurl_pkg::char_t                in_data,
	output logic                           in_stall,
	output logic                           rd_en,
	output logic [lurl_pkg::CHAR_BITS-1:0] rd_addr,
	input  logic [POSITION_BITS-1:0]       rd_data,
	output logic                           wr_en,
	output logic [lurl_pkg::CHAR_BITS-1:0] wr_addr,
	output logic [POSITION_BITS-1:0]       wr_data,
	input  logic                           out_free,
	output logic                           res_valid,
	output lurl_pkg::result_t              res_data
);
	import lurl_pkg::*;

	logic                     valid_s1;
	logic [CHAR_BITS-1:0]     char_s1;
	logic                     last_s1;
	logic                     byp_s1;
	logic [POSITION_BITS-1:0] bypd_s1;

	logic [CHAR_VALUES-1:0]   seen_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] start_q;
	logic [POSITION_BITS-1:0] best_q;
	logic                     ovf_q;

	logic                     accept;
	logic                     fire;
	logic                     full;
	logic [POSITION_BITS-1:0] prev_pos;
	logic                     hit;
	logic [POSITION_BITS-1:0] new_start;
	logic [POSITION_BITS-1:0] run_len;
	logic [POSITION_BITS-1:0] new_best;
	logic [POSITION_BITS-1:0] final_best;
	logic                     sat;

	assign fire     = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !fire;
	assign accept   = in_valid && !in_stall;
	assign full     = &pos_q;

	assign rd_en   = accept;
	assign rd_addr = in_data.char_byte;

	assign prev_pos  = byp_s1 ? bypd_s1 : rd_data;
	assign hit       = seen_q[char_s1] && (prev_pos >= start_q);
	assign new_start = hit ? prev_pos + POSITION_BITS'(1) : start_q;
	assign run_len   = pos_q - new_start + POSITION_BITS'(1);
	assign new_best  = (run_len > best_q) ? run_len : best_q;

	assign wr_en   = fire && !full;
	assign wr_addr = char_s1;
	assign wr_data = pos_q;

	assign final_best = full ? best_q : new_best;

	generate
		if (POSITION_BITS > LEN_BITS) begin : g_wide
			assign sat = |final_best[POSITION_BITS-1:LEN_BITS];
			assign res_data.longest_length = sat ? {LEN_BITS{1'b1}}
			                                     : final_best[LEN_BITS-1:0];
		end else begin : g_narrow
			assign sat = 1'b0;
			assign res_data.longest_length = LEN_BITS'(final_best);
		end
	endgenerate

	assign res_data.length_overflow = full || ovf_q || sat;
	assign res_valid                = fire && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= in_data.char_byte;
			last_s1 <= in_data.end_of_string;
			byp_s1  <= wr_en && (char_s1 == in_data.char_byte);
			bypd_s1 <= pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			pos_q   <= '0;
			start_q <= '0;
			best_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				seen_q  <= '0;
				pos_q   <= '0;
				start_q <= '0;
				best_q  <= '0;
				ovf_q   <= 1'b0;
			end else if (full) begin
				ovf_q <= 1'b1;
			end else begin
				seen_q[char_s1] <= 1'b1;
				pos_q           <= pos_q + POSITION_BITS'(1);
				start_q         <= new_start;
				best_q          <= new_best;
			end
		end
	end

endmodule

@@ tb/sv/longest_unique_run_length_unit_test.sv @@
// Testbench: random and directed byte strings checked against a longest-unique-run predictor
`timescale 1ns / 1ps
module longest_unique_run_length_unit_test;
	import lurl_pkg::*;

	localparam int POS_BITS = 16;
	localparam int unsigned POS_LIMIT = (1 << POS_BITS) - 1;
	localparam int RANDOM_CHARS = 1100;
	localparam int HOLD_CYCLES = 500;

	class unique_run_tracker;
		logic [POS_BITS-1:0] last_pos[CHAR_VALUES];
		bit                  seen[CHAR_VALUES];
		int unsigned         pos_count;
		int unsigned         win_start;
		int unsigned         best_len;
		bit                  overflowed;
		result_t             expected_runs[$];
		int                  mismatches;

		function new();
			mismatches = 0;
			clear_string();
		endfunction

		function void clear_string();
			foreach (seen[i])
				seen[i] = 1'b0;
			pos_count = 0;
			win_start = 0;
			best_len = 0;
			overflowed = 1'b0;
		endfunction

		function void take_char(char_t c);
			int unsigned p;
			int unsigned run;
			result_t r;
			if (pos_count >= POS_LIMIT) begin
				overflowed = 1'b1;
			end else begin
				p = pos_count;
				if (seen[c.char_byte] && last_pos[c.char_byte] >= win_start)
					win_start = last_pos[c.char_byte] + 1;
				run = p - win_start + 1;
				if (run > best_len)
					best_len = run;
				last_pos[c.char_byte] = POS_BITS'(p);
				seen[c.char_byte] = 1'b1;
				pos_count = p + 1;
			end
			if (c.end_of_string) begin
				r.longest_length = (best_len > 32'hFFFF) ? 16'hFFFF : best_len[15:0];
				r.length_overflow = overflowed || (best_len > 32'hFFFF);
				expected_runs.push_back(r);
				clear_string();
			end
		endfunction

		function void check_run(result_t got);
			result_t exp;
			if (expected_runs.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual length %0d overflow %0b",
					$time, got.longest_length, got.length_overflow);
				mismatches++;
				return;
			end
			exp = expected_runs.pop_front();
			if (got.longest_length !== exp.longest_length) begin
				$display("%0t: longest_length mismatch, expected %0d, actual %0d",
					$time, exp.longest_length, got.longest_length);
				mismatches++;
			end
			if (got.length_overflow !== exp.length_overflow) begin
				$display("%0t: length_overflow mismatch, expected %0b, actual %0b",
					$time, exp.length_overflow, got.length_overflow);
				mismatches++;
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n;
	logic    char_valid;
	logic    char_stall;
	char_t   char_data;
	logic    result_valid;
	logic    result_stall;
	result_t result_data;

	unique_run_tracker tracker = new();
	int  burst_left = 0;

	longest_unique_run_length_unit #(
		.POSITION_BITS(POS_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_data    (char_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	always #5 clk = ~clk;

	task automatic send_char(input char_t c);
		int gap;
		char_valid <= 1'b1;
		char_data <= c;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		tracker.take_char(c);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				char_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_text(input string s);
		char_t c;
		for (int i = 0; i < s.len(); i++) begin
			c.char_byte = s[i];
			c.end_of_string = (i == s.len() - 1);
			send_char(c);
		end
	endtask

	task automatic send_string(input int len, input int style);
		logic [7:0] base;
		logic [7:0] step;
		int         span;
		char_t      c;
		base = 8'($urandom_range(0, 255));
		step = 8'(2 * $urandom_range(0, 127) + 1);
		span = $urandom_range(1, 8);
		for (int i = 0; i < len; i++) begin
			case (style)
				0: c.char_byte = 8'($urandom_range(0, 255));
				1: c.char_byte = 8'(base + $urandom_range(0, span - 1));
				default: begin
					c.char_byte = 8'(base + i * step);
					if ($urandom_range(0, 15) == 0)
						c.char_byte = 8'($urandom_range(0, 255));
				end
			endcase
			c.end_of_string = (i == len - 1);
			send_char(c);
		end
	endtask

	initial begin
		char_t c;
		int    sent;
		int    len;
		arst_n <= 1'b0;
		char_valid <= 1'b0;
		char_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		c.char_byte = 8'h00;
		c.end_of_string = 1'b1;
		send_char(c);
		c.char_byte = 8'hFF;
		send_char(c);
		send_text("aa");
		send_text("abba");
		send_text("abcabcbb");
		send_text("pwwkew");
		send_text("dvdf");
		send_string(256, 2);

		sent = 0;
		while (sent < RANDOM_CHARS) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 300) : $urandom_range(1, 32);
			send_string(len, $urandom_range(0, 2));
			sent += len;
		end
		char_valid <= 1'b0;

		while (tracker.expected_runs.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		int cyc;
		int mode;
		int taken;
		bit held;
		result_stall <= 1'b0;
		cyc = 0;
		mode = 0;
		taken = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				tracker.check_run(result_data);
				taken++;
			end
			if (!held && taken == 20) begin
				// hold off the output long enough to back up the input
				held = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				cyc++;
				if (cyc % 50 == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 3) == 0);
					2: result_stall <= ($urandom_range(0, 3) != 0);
					default: result_stall <= cyc[0];
				endcase
			end
		end
	end

	initial begin
		#8_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
